[rtl/ffba_pkg.sv]
// Shared constants, types and codes of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [31:0]      HDR_BYTES      = 32'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] MAX_CNT        = CNT_W'(MAX_BLOCKS);
    localparam logic [31:0]      HEAP_BASE_RST  = 32'h0001_0000;
    localparam logic [31:0]      HEAP_LIMIT_RST = 32'hFFFF_FFFF;

    localparam logic [2:0] PADDR_BASE  = 3'd0;
    localparam logic [2:0] PADDR_LIMIT = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STS_REUSED       = 3'd0,
        STS_NEW          = 3'd1,
        STS_SIZE_ZERO    = 3'd2,
        STS_NO_MEMORY    = 3'd3,
        STS_NULL_FREE    = 3'd4,
        STS_MARKED_FREE  = 3'd5,
        STS_RELEASED_TOP = 3'd6,
        STS_FULL_MISSING = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic rd_issue;
        logic hit_set;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic special;
        logic more_to_read;
        logic rd_vld;
        logic rd_match;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/ffba_req_if.sv]
// Request channel of the allocator: allocate or free.
`default_nettype none

interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] req_size;
    logic [31:0] block_addr;

    modport source (output valid, output op, output req_size, output block_addr, input ready);
    modport sink   (input valid, input op, input req_size, input block_addr, output ready);
endinterface

`default_nettype wire

[rtl/ffba_rsp_if.sv]
// Response channel of the allocator: status and payload address.
`default_nettype none

interface ffba_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] payload_addr;

    modport source (output valid, output status, output payload_addr, input ready);
    modport sink   (input valid, input status, input payload_addr, output ready);
endinterface

`default_nettype wire

[rtl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator with its APB register file.
//
//   Port group     Dir    Handshake                  Carries
//   i_req          in     valid/ready                op, req_size, block_addr
//   o_rsp          out    valid/ready                status, payload_addr
//   APB            in     psel/penable/pwrite        heap_base @0x0, heap_limit @0x4
//
// A zero size or null free goes from the decide state straight to commit.
// Any other request scans the block table one entry at a time, up to
// MAX_BLOCKS entries, because the block table has one read port.
// Reset is synchronous; the table needs no clearing pass and no wait.
// A new request is taken while an earlier result waits in the output register;
// its commit then holds until that result is transferred.
`default_nettype none

module first_fit_block_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ffba_req_if.sink         i_req,
    ffba_rsp_if.source       o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ffba_pkg::*;

    logic [31:0] r_heap_base;
    logic [31:0] r_heap_limit;
    logic        cfg_wr;
    logic        base_wr;
    t_dp_cmd     cmd;
    t_dp_sts     sts;

    // Only paddr[2] selects the register; the low bits are ignored.
    assign cfg_wr  = psel && penable && pwrite;
    assign base_wr = cfg_wr && (paddr[2] == PADDR_BASE[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= HEAP_BASE_RST;
            r_heap_limit <= HEAP_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == PADDR_LIMIT[2]) begin
                r_heap_limit <= pwdata;
            end else begin
                r_heap_base <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == PADDR_LIMIT[2]) ? r_heap_limit : r_heap_base;
    assign pready = 1'b1;

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_req.op),
        .i_req_size     (i_req.req_size),
        .i_block_addr   (i_req.block_addr),
        .i_base_wr      (base_wr),
        .i_base_val     (pwdata),
        .i_heap_limit   (r_heap_limit),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_payload_addr (o_rsp.payload_addr)
    );

endmodule

`default_nettype wire

[rtl/ffba_ctrl.sv]
// Controller state machine that sequences setup, table scan and commit.
`default_nettype none

module ffba_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ffba_pkg::t_dp_sts i_sts,
    output ffba_pkg::t_dp_cmd      o_cmd
);
    import ffba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = i_sts.special ? S_COMMIT : S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.rd_vld && i_sts.rd_match) begin
                    n_state = S_COMMIT;
                end else if (!i_sts.more_to_read) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECIDE: begin
                o_cmd = '0;
            end
            S_SCAN: begin
                // A hit on the entry read last cycle wins over the next read.
                if (i_sts.rd_vld && i_sts.rd_match) begin
                    o_cmd.hit_set = 1'b1;
                end else if (i_sts.more_to_read) begin
                    o_cmd.rd_issue = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = !i_sts.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/ffba_dp.sv]
// Datapath: block table memory, scan pointer, heap top and result register.
`default_nettype none

module ffba_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ffba_pkg::t_dp_cmd i_cmd,
    output ffba_pkg::t_dp_sts      o_sts,
    input  wire logic              i_op,
    input  wire logic [31:0]       i_req_size,
    input  wire logic [31:0]       i_block_addr,
    input  wire logic              i_base_wr,
    input  wire logic [31:0]       i_base_val,
    input  wire logic [31:0]       i_heap_limit,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [2:0]             o_status,
    output logic [31:0]            o_payload_addr
);
    import ffba_pkg::*;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_mem_q;

    logic             r_op;
    logic [31:0]      r_size;
    logic [31:0]      r_addr;
    logic [CNT_W-1:0] r_scan_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    logic             r_hit;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_top;
    logic             r_out_vld;
    logic [2:0]       r_out_status;
    logic [31:0]      r_out_addr;

    logic        size_zero;
    logic        addr_null;
    logic        rd_match;
    logic        is_top;
    logic        no_mem;
    logic [33:0] new_top;
    t_status     code;
    logic [31:0] pay_addr;
    logic        wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry      wr_data;

    assign size_zero = (r_size == 32'd0);
    assign addr_null = (r_addr == 32'd0);

    // Allocate wants a free block that is large enough; free wants the
    // payload address, taken without wrap past 32 bits.
    always_comb begin
        if (r_op == OP_ALLOC) begin
            rd_match = r_mem_q.free && (r_mem_q.size >= r_size);
        end else begin
            rd_match = (({1'b0, r_mem_q.start} + {1'b0, HDR_BYTES}) == {1'b0, r_addr});
        end
    end

    assign is_top  = (r_count == (CNT_W'(r_rd_idx) + CNT_W'(1)));
    assign new_top = {2'b00, r_top} + {2'b00, HDR_BYTES} + {2'b00, r_size};
    assign no_mem  = (new_top > {2'b00, i_heap_limit});

    always_comb begin
        pay_addr = 32'd0;
        if (r_op == OP_ALLOC) begin
            if (size_zero) begin
                code = STS_SIZE_ZERO;
            end else if (r_hit) begin
                code     = STS_REUSED;
                pay_addr = r_mem_q.start + HDR_BYTES;
            end else if (r_count == MAX_CNT) begin
                code = STS_FULL_MISSING;
            end else if (no_mem) begin
                code = STS_NO_MEMORY;
            end else begin
                code     = STS_NEW;
                pay_addr = r_top + HDR_BYTES;
            end
        end else begin
            if (addr_null) begin
                code = STS_NULL_FREE;
            end else if (r_hit) begin
                code = is_top ? STS_RELEASED_TOP : STS_MARKED_FREE;
            end else begin
                code = STS_FULL_MISSING;
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_rd_idx;
        wr_data = r_mem_q;
        case (code)
            STS_REUSED: begin
                wr_en        = i_cmd.commit;
                wr_data.free = 1'b0;
            end
            STS_MARKED_FREE: begin
                wr_en        = i_cmd.commit;
                wr_data.free = 1'b1;
            end
            STS_NEW: begin
                wr_en   = i_cmd.commit;
                wr_idx  = r_count[IDX_W-1:0];
                wr_data = '{start: r_top, size: r_size, free: 1'b0};
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_mem_q  <= r_mem[r_scan_idx[IDX_W-1:0]];
            r_rd_idx <= r_scan_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_size <= i_req_size;
            r_addr <= i_block_addr;
        end
        if (i_cmd.commit) begin
            r_out_status <= code;
            r_out_addr   <= pay_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_count    <= '0;
            r_top      <= HEAP_BASE_RST;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.capture) begin
                r_scan_idx <= '0;
                r_hit      <= 1'b0;
            end else if (i_cmd.rd_issue) begin
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
            if (i_cmd.hit_set) begin
                r_hit <= 1'b1;
            end
            if (i_base_wr && (r_count == '0)) begin
                r_top <= i_base_val;
            end
            if (i_cmd.commit && (code == STS_NEW)) begin
                r_count <= r_count + CNT_W'(1);
                r_top   <= new_top[31:0];
            end
            if (i_cmd.commit && (code == STS_RELEASED_TOP)) begin
                r_count <= r_count - CNT_W'(1);
                r_top   <= r_mem_q.start;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.special      = ((r_op == OP_ALLOC) && size_zero) || ((r_op == OP_FREE) && addr_null);
    assign o_sts.more_to_read = (r_scan_idx < r_count);
    assign o_sts.rd_vld       = r_rd_vld;
    assign o_sts.rd_match     = rd_match;
    assign o_sts.out_busy     = r_out_vld && !i_out_ready;

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_payload_addr = r_out_addr;

endmodule

`default_nettype wire

[rtl/ffba_checker.sv]
// Port-level assertions of the allocator and their bind to the top level.
`default_nettype none

module ffba_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [2:0]  i_rsp_status,
    input wire logic [31:0] i_rsp_addr
);
    import ffba_pkg::*;

    // Every failure and every free reports a null payload address.
    a_null_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != STS_REUSED) && (i_rsp_status != STS_NEW))
        |-> (i_rsp_addr == 32'd0))
        else $error("payload address not zero on a failure or free");

    // A request is worked on alone: no second transfer right after one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken in the cycle after a transfer");

    // A new result never appears straight after a request transfer.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_valid && i_req_ready))
        else $error("result appeared too soon after a request");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready)
        |=> (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_addr)))
        else $error("stalled result changed");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_addr   (o_rsp.payload_addr)
);

`default_nettype wire

[tb/sv/tb_first_fit_block_allocator.sv]
// Self-checking testbench of the first-fit block allocator with a built-in heap predictor.
module tb_first_fit_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic        op;
        logic [31:0] size;
        logic [31:0] addr;
    } req_item_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] addr;
    } outcome_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ffba_req_if req_if();
    ffba_rsp_if rsp_if();

    first_fit_block_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted heap state, updated when a request transfer happens.
    logic [31:0] blk_start [MAX_BLOCKS];
    logic [31:0] blk_size  [MAX_BLOCKS];
    logic        blk_free  [MAX_BLOCKS];
    int          blk_count   = 0;
    logic [31:0] heap_top_m  = HEAP_BASE_RST;
    logic [31:0] base_reg    = HEAP_BASE_RST;
    logic [31:0] limit_reg   = HEAP_LIMIT_RST;

    req_item_t pending_reqs[$];
    outcome_t  expected_outcomes[$];
    req_item_t on_wire;
    outcome_t  want;
    bit        sender_hold = 1'b0;
    int        burst_left  = 8;
    int        gap_left    = 0;
    rx_mode_t  rx_mode     = RX_OPEN;
    int        rx_left     = 0;
    int        rx_tick     = 0;
    int        quiet_cycles = 0;
    int        failures    = 0;

    function automatic outcome_t next_outcome(req_item_t r);
        outcome_t    o;
        logic [32:0] new_top;
        bit          done;
        o.status = STS_FULL_MISSING;
        o.addr   = '0;
        done     = 1'b0;
        if (r.op == OP_ALLOC) begin
            if (r.size == '0) begin
                o.status = STS_SIZE_ZERO;
            end else begin
                for (int i = 0; i < blk_count && !done; i++) begin
                    if (blk_free[i] && blk_size[i] >= r.size) begin
                        blk_free[i] = 1'b0;
                        o.status    = STS_REUSED;
                        o.addr      = blk_start[i] + HDR_BYTES;
                        done        = 1'b1;
                    end
                end
                if (!done) begin
                    // The limit test is done one bit wider; the sum can still wrap past 33 bits.
                    new_top = {1'b0, heap_top_m} + {1'b0, HDR_BYTES} + {1'b0, r.size};
                    if (blk_count >= MAX_BLOCKS) begin
                        o.status = STS_FULL_MISSING;
                    end else if (new_top > {1'b0, limit_reg}) begin
                        o.status = STS_NO_MEMORY;
                    end else begin
                        blk_start[blk_count] = heap_top_m;
                        blk_size[blk_count]  = r.size;
                        blk_free[blk_count]  = 1'b0;
                        blk_count++;
                        o.status   = STS_NEW;
                        o.addr     = heap_top_m + HDR_BYTES;
                        heap_top_m = new_top[31:0];
                    end
                end
            end
        end else if (r.addr == '0) begin
            o.status = STS_NULL_FREE;
        end else begin
            for (int i = 0; i < blk_count && !done; i++) begin
                if ({1'b0, blk_start[i]} + {1'b0, HDR_BYTES} == {1'b0, r.addr}) begin
                    done = 1'b1;
                    if (i == blk_count - 1) begin
                        heap_top_m = blk_start[i];
                        blk_count--;
                        o.status = STS_RELEASED_TOP;
                    end else begin
                        blk_free[i] = 1'b1;
                        o.status    = STS_MARKED_FREE;
                    end
                end
            end
        end
        return o;
    endfunction

    function automatic req_item_t random_request();
        req_item_t   r;
        int unsigned roll;
        int unsigned k;
        r.op   = OP_ALLOC;
        r.size = $urandom();
        r.addr = $urandom();
        roll   = $urandom_range(0, 99);
        if (roll < 58) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                r.size = '0;
            end else if (roll < 12) begin
                // Keep the full-width random size.
            end else if (roll < 32 && blk_count != 0) begin
                k      = $urandom_range(0, blk_count - 1);
                r.size = blk_size[k] + 32'($urandom_range(0, 2)) - 32'd1;
            end else if (roll < 38) begin
                r.size = 32'd1 << $urandom_range(0, 31);
            end else begin
                r.size = $urandom_range(1, 64);
            end
        end else begin
            r.op = OP_FREE;
            roll = $urandom_range(0, 99);
            if (roll < 75 && blk_count != 0) begin
                k      = (roll < 30) ? blk_count - 1 : $urandom_range(0, blk_count - 1);
                r.addr = blk_start[k] + HDR_BYTES;
            end else if (roll < 85) begin
                r.addr = '0;
            end else if (roll < 93 && blk_count != 0) begin
                k      = $urandom_range(0, blk_count - 1);
                r.addr = blk_start[k] + HDR_BYTES + 32'($urandom_range(0, 1) * 2) - 32'd1;
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Request side: bursts of transfers separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                expected_outcomes.push_back(next_outcome(on_wire));
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (!sender_hold && pending_reqs.size() != 0) begin
                    on_wire = pending_reqs.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.op         <= on_wire.op;
                    req_if.req_size   <= on_wire.size;
                    req_if.block_addr <= on_wire.addr;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response side: compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_outcomes.size() == 0) begin
                    note_failure($sformatf("result with nothing pending: status=%0d addr=%h",
                                           rsp_if.status, rsp_if.payload_addr));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (rsp_if.status !== want.status)
                        note_failure($sformatf("status expected %0d got %0d",
                                               want.status, rsp_if.status));
                    if (rsp_if.payload_addr !== want.addr)
                        note_failure($sformatf("payload_addr expected %h got %h",
                                               want.addr, rsp_if.payload_addr));
                end
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(32, 256);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:  rsp_if.ready <= 1'b1;
                RX_LIGHT: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default:  rsp_if.ready <= ((rx_tick % 8) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || req_if.valid || expected_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic settle();
        wait_quiet();
        repeat (8) @(negedge i_clk);
    endtask

    task automatic queue_item(input req_item_t r);
        while (pending_reqs.size() != 0)
            @(negedge i_clk);
        pending_reqs.push_back(r);
    endtask

    task automatic run_one(input logic op, input logic [31:0] size, input logic [31:0] addr);
        req_item_t r;
        r.op   = op;
        r.size = size;
        r.addr = addr;
        pending_reqs.push_back(r);
        wait_quiet();
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            queue_item(random_request());
            if (i == n / 2) begin
                // Hold the sender until the block has drained completely.
                sender_hold = 1'b1;
                while (req_if.valid || expected_outcomes.size() != 0)
                    @(negedge i_clk);
                sender_hold = 1'b0;
            end
        end
    endtask

    // Freeing the top entry repeatedly empties the table.
    task automatic release_all();
        while (blk_count != 0)
            run_one(OP_FREE, $urandom(), blk_start[blk_count - 1] + HDR_BYTES);
    endtask

    task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (a == PADDR_BASE) begin
            base_reg = d;
            if (blk_count == 0)
                heap_top_m = d;
        end else begin
            limit_reg = d;
        end
    endtask

    task automatic reg_read(input logic [2:0] a, output logic [31:0] d);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_heap(input logic [31:0] base, input logic [31:0] lim);
        logic [31:0] got;
        settle();
        reg_write(PADDR_LIMIT, lim);
        reg_write(PADDR_BASE, base);
        reg_read(PADDR_BASE, got);
        if (got !== base_reg)
            note_failure($sformatf("heap_base read %h, expected %h", got, base_reg));
        reg_read(PADDR_LIMIT, got);
        if (got !== limit_reg)
            note_failure($sformatf("heap_limit read %h, expected %h", got, limit_reg));
    endtask

    initial begin
        logic [31:0] first_payload;
        req_item_t   r;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.op         = OP_ALLOC;
        req_if.req_size   = '0;
        req_if.block_addr = '0;
        rsp_if.ready      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset configuration, one request at a time.
        run_one(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
        run_one(OP_ALLOC, 32'd1, 32'd0);
        first_payload = blk_start[0] + HDR_BYTES;
        run_one(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
        run_one(OP_ALLOC, 32'd100, 32'd0);
        run_one(OP_ALLOC, 32'd8, 32'd0);
        run_one(OP_FREE, 32'hFFFF_FFFF, 32'd0);
        run_one(OP_FREE, 32'd0, 32'hFFFF_FFFF);
        run_one(OP_FREE, 32'd0, first_payload);
        run_one(OP_FREE, 32'd0, first_payload);
        run_one(OP_ALLOC, 32'd1, 32'd0);
        run_one(OP_FREE, 32'd0, first_payload);
        run_one(OP_ALLOC, 32'd2, 32'd0);
        run_one(OP_FREE, 32'd0, blk_start[1] + HDR_BYTES);
        run_one(OP_ALLOC, 32'd50, 32'd0);
        repeat (4) run_one(OP_FREE, 32'd0, blk_start[blk_count - 1] + HDR_BYTES);
        run_one(OP_FREE, 32'd0, first_payload);
        run_one(OP_ALLOC, HEAP_LIMIT_RST - heap_top_m - HDR_BYTES, 32'd0);
        run_one(OP_ALLOC, 32'd1, 32'd0);
        run_one(OP_FREE, 32'd0, blk_start[0] + HDR_BYTES);
        run_one(OP_ALLOC, HEAP_LIMIT_RST - heap_top_m - HDR_BYTES + 32'd1, 32'd0);

        // Fill the table past its capacity, then mix at random.
        repeat (70) begin
            r.op   = OP_ALLOC;
            r.size = $urandom_range(1, 32);
            r.addr = $urandom();
            queue_item(r);
        end
        run_random(130);

        settle();
        release_all();
        set_heap(32'h0000_0000, 32'hFFFF_FFFF);
        run_random(180);

        settle();
        release_all();
        set_heap(32'h0000_2000, 32'h0000_2258);
        run_random(180);

        // The table is not empty here, so the new base is only stored.
        set_heap(32'h4000_0000, 32'h7FFF_FFFF);
        run_random(180);

        settle();
        release_all();
        set_heap(32'hFFFF_FF00, 32'hFFFF_FFFF);
        run_random(150);

        settle();
        release_all();
        set_heap(32'hFFFF_FFFF, 32'h0000_0000);
        run_random(60);

        settle();
        set_heap(32'h0001_0000, 32'h0001_0BB8);
        run_random(180);

        settle();
        repeat (80) @(negedge i_clk);
        if (expected_outcomes.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_outcomes.size()));
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
